[rtl/tmvc_pkg.sv]
package tmvc_pkg;

   localparam int GROUP_SIZE_DEF = 3;
   // power of two, so the pointers wrap on their own
   localparam int QUEUE_DEPTH    = 2;

   localparam int RAW_W      = 10;
   localparam int PRES_W     = 12;
   localparam int SPAN_W     = 16;
   localparam int POS_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // a + b - 2m spans -2046 .. 2046
   localparam int DIFF_W = RAW_W + 2;
   localparam int ABS_W  = RAW_W + 1;
   localparam int PROD_W = SPAN_W + ABS_W;
   // 2*span*|a+b-2m| + 2|b-a| stays below 2**28 since |a+b-2m| <= 2046
   localparam int DVD_W  = PROD_W + 1;
   localparam int DVS_W  = ABS_W + 1;

   localparam logic [CSR_IDX_W-1:0] CSR_CAL_LEFT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_RIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_TOP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_BOTTOM  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESSURE    = 3'd6;

   localparam logic [RAW_W-1:0]  CAL_LEFT_RST     = 10'd957;
   localparam logic [RAW_W-1:0]  CAL_RIGHT_RST    = 10'd54;
   localparam logic [RAW_W-1:0]  CAL_TOP_RST      = 10'd936;
   localparam logic [RAW_W-1:0]  CAL_BOTTOM_RST   = 10'd92;
   localparam logic [SPAN_W-1:0] WIDTH_RST        = 16'd18750;
   localparam logic [SPAN_W-1:0] HEIGHT_RST       = 16'd14100;
   localparam logic [PRES_W-1:0] PRESSURE_MIN_RST = 12'd3;

   typedef struct packed {
      logic [RAW_W-1:0]  sample_x;
      logic [RAW_W-1:0]  sample_y;
      logic [PRES_W-1:0] sample_pressure;
   } sample_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x_centi;
      logic signed [POS_W-1:0] pos_y_centi;
      logic                    contact_valid;
   } result_type;

   typedef struct packed {
      logic [RAW_W-1:0]  cal_left;
      logic [RAW_W-1:0]  cal_right;
      logic [RAW_W-1:0]  cal_top;
      logic [RAW_W-1:0]  cal_bottom;
      logic [SPAN_W-1:0] width_centi_mm;
      logic [SPAN_W-1:0] height_centi_mm;
      logic [PRES_W-1:0] pressure_min;
   } cfg_type;

   typedef struct packed {
      logic [RAW_W-1:0] x;
      logic [RAW_W-1:0] y;
      logic             contact;
      logic             last;
   } entry_type;

   typedef struct packed {
      logic              start;
      logic [RAW_W-1:0]  m;
      logic [RAW_W-1:0]  a;
      logic [RAW_W-1:0]  b;
      logic [SPAN_W-1:0] span;
   } map_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [POS_W-1:0] value;
   } map_rsp_type;

endpackage

[rtl/touch_median_vote_calibrator.sv]
// Touch sample calibrator: groups raw (x, y, pressure) samples, votes on
// contact and maps the median position into hundredths of a millimetre.
// req_*: one sample per transaction. rsp_*: one result per completed group of
// GROUP_SIZE samples; a group without a contact majority repeats the last
// position with contact_valid low. csr_*: register writes, index 0..6 in the
// order cal_left, cal_right, cal_top, cal_bottom, width, height, pressure_min;
// other indices are dropped. csr_ready is always high; write only when idle.
// Samples enter a two-entry queue at one per cycle while it is not full; the
// back end drains it at one sample per cycle while it collects a group. After
// the last sample of a group it runs the median search, operand set-up and the
// multiply, the restoring divider (one quotient bit a cycle, x and y in
// parallel) and the pick-up and registering of the result; a group without a
// contact majority skips straight to the result.
// The result sits in an output register; while rsp_ready is low the back end
// still collects the next group, and stalls only when its next result is due.
// Reset restores the default calibration, clears the partial group, the queue
// and the held position (0, 0), and drops any pending result.
module touch_median_vote_calibrator #(
   parameter int GROUP_SIZE = tmvc_pkg::GROUP_SIZE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tmvc_pkg::sample_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tmvc_pkg::result_type                rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tmvc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tmvc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tmvc_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      q_valid, q_pop;
   entry_type q_entry;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CAL_LEFT:   cfg_in.cal_left        = csr_wdata[RAW_W-1:0];
            CSR_CAL_RIGHT:  cfg_in.cal_right       = csr_wdata[RAW_W-1:0];
            CSR_CAL_TOP:    cfg_in.cal_top         = csr_wdata[RAW_W-1:0];
            CSR_CAL_BOTTOM: cfg_in.cal_bottom      = csr_wdata[RAW_W-1:0];
            CSR_WIDTH:      cfg_in.width_centi_mm  = csr_wdata[SPAN_W-1:0];
            CSR_HEIGHT:     cfg_in.height_centi_mm = csr_wdata[SPAN_W-1:0];
            CSR_PRESSURE:   cfg_in.pressure_min    = csr_wdata[PRES_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cal_left        <= CAL_LEFT_RST;
         cfg_ff.cal_right       <= CAL_RIGHT_RST;
         cfg_ff.cal_top         <= CAL_TOP_RST;
         cfg_ff.cal_bottom      <= CAL_BOTTOM_RST;
         cfg_ff.width_centi_mm  <= WIDTH_RST;
         cfg_ff.height_centi_mm <= HEIGHT_RST;
         cfg_ff.pressure_min    <= PRESSURE_MIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tmvc_front #(
      .GROUP_SIZE (GROUP_SIZE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_entry)
   );

   tmvc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_entry),
      .pop_valid  (q_valid),
      .pop_ready  (q_pop),
      .pop_data   (q_entry)
   );

   tmvc_back #(
      .GROUP_SIZE (GROUP_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (q_valid),
      .pop_ready (q_pop),
      .pop_data  (q_entry),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // nothing is left queued or pending once reset has been seen
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !q_valid)
      else $error("queue or result pending after reset");

   // only the closing sample of a group may lead to a new result
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_pop && !q_entry.last) |=> !$rose(rsp_valid))
      else $error("result raised by a sample that does not close its group");

endmodule

[rtl/tmvc_queue.sv]
module tmvc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  tmvc_pkg::entry_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output tmvc_pkg::entry_type pop_data
);
   import tmvc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/tmvc_front.sv]
module tmvc_front #(
   parameter int GROUP_SIZE = tmvc_pkg::GROUP_SIZE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tmvc_pkg::cfg_type    cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tmvc_pkg::sample_type req_data,
   output logic                 push_valid,
   input  logic                 push_ready,
   output tmvc_pkg::entry_type  push_data
);
   import tmvc_pkg::*;

   localparam int SLOT_W = $clog2(GROUP_SIZE + 1);

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              last, accept;

   assign last       = slot_ff == SLOT_W'(GROUP_SIZE - 1);
   assign accept     = req_valid && push_ready;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   always_comb begin
      push_data.x       = req_data.sample_x;
      push_data.y       = req_data.sample_y;
      push_data.contact = req_data.sample_pressure > cfg.pressure_min;
      push_data.last    = last;
      slot_in           = slot_ff;
      if (accept) begin
         slot_in = last ? '0 : slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule

[rtl/tmvc_axis_map.sv]
module tmvc_axis_map (
   input  logic                  clock,
   input  logic                  reset,
   input  tmvc_pkg::map_req_type map_req,
   output tmvc_pkg::map_rsp_type map_rsp
);
   import tmvc_pkg::*;

   localparam int ITER_W = $clog2(DVD_W);
   localparam logic [DVD_W-1:0] POS_LIM = DVD_W'(2 ** (POS_W - 1) - 1);
   localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(2 ** (POS_W - 1));

   typedef enum logic [3:0] {
      MAP_IDLE = 4'b0001,
      MAP_MUL  = 4'b0010,
      MAP_DIV  = 4'b0100,
      MAP_DONE = 4'b1000
   } map_state_type;

   map_state_type     state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [ABS_W-1:0]  abs_s_ff, ad_ff;
   logic [SPAN_W-1:0] span_ff;
   logic              neg_ff, eq_ff;
   logic [DVD_W-1:0]  dq_ff, dq_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;

   logic [DIFF_W-1:0] sum_w, abs_w;
   logic              s_neg, den_neg;
   logic [RAW_W-1:0]  ends_diff;
   logic [PROD_W-1:0] prod;
   logic [DVS_W-1:0]  divisor;
   logic [DVS_W:0]    trial, trial_sub;
   logic [POS_W-1:0]  mag;

   // operand set-up on start
   always_comb begin
      sum_w     = DIFF_W'(map_req.a) + DIFF_W'(map_req.b) - {1'b0, map_req.m, 1'b0};
      s_neg     = sum_w[DIFF_W-1];
      abs_w     = s_neg ? ~sum_w + 1'b1 : sum_w;
      den_neg   = map_req.b < map_req.a;
      ends_diff = den_neg ? map_req.a - map_req.b : map_req.b - map_req.a;
   end

   // one restoring divide step a cycle; quotient bits shift into dq_ff
   always_comb begin
      prod      = PROD_W'(span_ff) * PROD_W'(abs_s_ff);
      divisor   = {ad_ff, 1'b0};
      trial     = {rem_ff, dq_ff[DVD_W-1]};
      trial_sub = trial - {1'b0, divisor};
      rem_in    = rem_ff;
      dq_in     = dq_ff;
      iter_in   = iter_ff;
      state_in  = state_ff;
      case (state_ff)
         MAP_MUL: begin
            dq_in    = {prod, 1'b0} + DVD_W'(ad_ff);
            rem_in   = '0;
            iter_in  = '0;
            state_in = MAP_DIV;
         end
         MAP_DIV: begin
            if (trial >= {1'b0, divisor}) begin
               rem_in = trial_sub[DVS_W-1:0];
               dq_in  = {dq_ff[DVD_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DVS_W-1:0];
               dq_in  = {dq_ff[DVD_W-2:0], 1'b0};
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(DVD_W - 1)) begin
               state_in = MAP_DONE;
            end
         end
         MAP_IDLE, MAP_DONE: ;
         default: state_in = MAP_IDLE;
      endcase
      if (map_req.start) begin
         state_in = MAP_MUL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MAP_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      if (map_req.start) begin
         abs_s_ff <= abs_w[ABS_W-1:0];
         ad_ff    <= {ends_diff, 1'b0};
         span_ff  <= map_req.span;
         neg_ff   <= s_neg ^ den_neg;
         eq_ff    <= map_req.a == map_req.b;
      end
   end

   // round-half-away already folded into the dividend; sign and clamp here
   always_comb begin
      mag          = dq_ff[POS_W-1:0];
      map_rsp.done = state_ff == MAP_DONE;
      if (eq_ff) begin
         map_rsp.value = '0;
      end else if (!neg_ff) begin
         map_rsp.value = (dq_ff > POS_LIM) ? POS_LIM[POS_W-1:0] : mag;
      end else begin
         map_rsp.value = (dq_ff > NEG_LIM) ? NEG_LIM[POS_W-1:0] : ~mag + 1'b1;
      end
   end

endmodule

[rtl/tmvc_back.sv]
module tmvc_back #(
   parameter int GROUP_SIZE = tmvc_pkg::GROUP_SIZE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tmvc_pkg::cfg_type    cfg,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  tmvc_pkg::entry_type  pop_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tmvc_pkg::result_type rsp_data
);
   import tmvc_pkg::*;

   localparam int CNT_W = $clog2(GROUP_SIZE + 1);
   localparam int MED_K = GROUP_SIZE / 2;

   typedef enum logic [3:0] {
      ST_COLLECT = 4'b0001,
      ST_SEARCH  = 4'b0010,
      ST_MAP     = 4'b0100,
      ST_EMIT    = 4'b1000
   } back_state_type;

   back_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] votes_ff, votes_in;
   logic             ok_ff, ok_in;
   logic             start_ff, start_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff, rsp_data_in;
   logic [POS_W-1:0] held_x_ff, held_x_in;
   logic [POS_W-1:0] held_y_ff, held_y_in;
   logic [RAW_W-1:0] med_x_ff, med_x_in;
   logic [RAW_W-1:0] med_y_ff, med_y_in;
   logic [RAW_W-1:0] xs_ff [GROUP_SIZE];
   logic [RAW_W-1:0] ys_ff [GROUP_SIZE];

   logic             pop, searching, shift_en, load, majority;
   logic [RAW_W-1:0] top_x, top_y;
   logic [CNT_W-1:0] votes_tot, lt_x, le_x, lt_y, le_y;
   logic             hit_x, hit_y;
   map_req_type      map_x_req, map_y_req;
   map_rsp_type      map_x_rsp, map_y_rsp;

   assign pop_ready = state_ff == ST_COLLECT;
   assign pop       = pop_valid && pop_ready;
   assign searching = state_ff == ST_SEARCH;
   assign shift_en  = pop || searching;
   assign top_x     = searching ? xs_ff[0] : pop_data.x;
   assign top_y     = searching ? ys_ff[0] : pop_data.y;
   assign votes_tot = votes_ff + CNT_W'(pop_data.contact);
   assign majority  = {votes_tot, 1'b0} > (CNT_W + 1)'(GROUP_SIZE);
   assign load      = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // samples shift in at the top; during the search the line rotates so that
   // each entry in turn sits at the bottom as the median candidate
   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int i = 0; i < GROUP_SIZE - 1; i++) begin
            xs_ff[i] <= xs_ff[i+1];
            ys_ff[i] <= ys_ff[i+1];
         end
         xs_ff[GROUP_SIZE-1] <= top_x;
         ys_ff[GROUP_SIZE-1] <= top_y;
      end
   end

   // candidate is the median when fewer than K+1 lie below it and more than K
   // lie at or below it
   always_comb begin
      lt_x = '0;
      le_x = '0;
      lt_y = '0;
      le_y = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
         lt_x = lt_x + CNT_W'(xs_ff[j] < xs_ff[0]);
         le_x = le_x + CNT_W'(xs_ff[j] <= xs_ff[0]);
         lt_y = lt_y + CNT_W'(ys_ff[j] < ys_ff[0]);
         le_y = le_y + CNT_W'(ys_ff[j] <= ys_ff[0]);
      end
      hit_x = (lt_x <= CNT_W'(MED_K)) && (le_x > CNT_W'(MED_K));
      hit_y = (lt_y <= CNT_W'(MED_K)) && (le_y > CNT_W'(MED_K));
   end

   always_comb begin
      map_x_req.start = start_ff;
      map_x_req.m     = med_y_ff;
      map_x_req.a     = cfg.cal_left;
      map_x_req.b     = cfg.cal_right;
      map_x_req.span  = cfg.width_centi_mm;
      map_y_req.start = start_ff;
      map_y_req.m     = med_x_ff;
      map_y_req.a     = cfg.cal_bottom;
      map_y_req.b     = cfg.cal_top;
      map_y_req.span  = cfg.height_centi_mm;
   end

   tmvc_axis_map u_map_x (
      .clock   (clock),
      .reset   (reset),
      .map_req (map_x_req),
      .map_rsp (map_x_rsp)
   );

   tmvc_axis_map u_map_y (
      .clock   (clock),
      .reset   (reset),
      .map_req (map_y_req),
      .map_rsp (map_y_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      votes_in     = votes_ff;
      ok_in        = ok_ff;
      start_in     = 1'b0;
      med_x_in     = med_x_ff;
      med_y_in     = med_y_ff;
      held_x_in    = held_x_ff;
      held_y_in    = held_y_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_COLLECT: begin
            if (pop) begin
               if (pop_data.last) begin
                  votes_in = '0;
                  ok_in    = majority;
                  cnt_in   = '0;
                  state_in = majority ? ST_SEARCH : ST_EMIT;
               end else begin
                  votes_in = votes_tot;
               end
            end
         end
         ST_SEARCH: begin
            cnt_in = cnt_ff + 1'b1;
            if (hit_x) begin
               med_x_in = xs_ff[0];
            end
            if (hit_y) begin
               med_y_in = ys_ff[0];
            end
            if (cnt_ff == CNT_W'(GROUP_SIZE - 1)) begin
               start_in = 1'b1;
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            // done still shows the previous group while start is in flight
            if (!start_ff && map_x_rsp.done && map_y_rsp.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load) begin
               if (ok_ff) begin
                  held_x_in = map_x_rsp.value;
                  held_y_in = map_y_rsp.value;
               end
               rsp_data_in.pos_x_centi   = ok_ff ? map_x_rsp.value : held_x_ff;
               rsp_data_in.pos_y_centi   = ok_ff ? map_y_rsp.value : held_y_ff;
               rsp_data_in.contact_valid = ok_ff;
               rsp_valid_in              = 1'b1;
               state_in                  = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         cnt_ff       <= '0;
         votes_ff     <= '0;
         ok_ff        <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_x_ff    <= '0;
         held_y_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         votes_ff     <= votes_in;
         ok_ff        <= ok_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         held_x_ff    <= held_x_in;
         held_y_ff    <= held_y_in;
      end
   end

   always_ff @(posedge clock) begin
      med_x_ff    <= med_x_in;
      med_y_ff    <= med_y_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
